/* rtl/core/fat32_cluster_chain_sector_walker_macros.svh */
// assertion macros shared by the walker checker
// each macro expects clk and rst_n in the scope where it is used
`ifndef FAT32_CLUSTER_CHAIN_SECTOR_WALKER_MACROS_SVH
`define FAT32_CLUSTER_CHAIN_SECTOR_WALKER_MACROS_SVH

// same-cycle implication
`define FCW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("walker assertion failed");

// next-cycle implication
`define FCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("walker assertion failed");

`endif

/* rtl/core/fcw_pkg.sv */
// ----------------------------------------------------------------------------
// fcw_pkg
// types, codes and constants of the fat32 cluster chain sector walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcw_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int FAT_WORDS    = SECTOR_BYTES / 4;
    localparam int FAT_SHIFT    = $clog2(FAT_WORDS);

    localparam int CLUSTER_W = 28;
    localparam int ADDR_W    = 32;
    localparam int SPC_W     = 8;
    localparam int WIDX_W    = 7;
    localparam int CNT_W     = 10;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CLUSTER_W-1:0] CHAIN_END   = 28'hFFF_FFF8;
    localparam logic [CLUSTER_W-1:0] MIN_CLUSTER = 28'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAT_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPC        = 2'd2;

    typedef enum logic [1:0] {
        OP_START     = 2'd0,
        OP_NEXT      = 2'd1,
        OP_FAT_ENTRY = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_FAT       = 3'd1,
        KIND_EOF       = 3'd2,
        KIND_CHAIN_END = 3'd3,
        KIND_ERROR     = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_STREAM = 4'b0010,
        PH_WAIT   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [ADDR_W-1:0] data_start;
        logic [ADDR_W-1:0] fat_start;
        logic [SPC_W-1:0]  spc;
    } walk_cfg_t;

    typedef struct packed {
        phase_t               phase;
        logic [CLUSTER_W-1:0] chain_cluster;
        logic [ADDR_W-1:0]    cluster_base;
        logic [SPC_W-1:0]     sector_in_cluster;
        logic [ADDR_W-1:0]    bytes_done;
        logic [ADDR_W-1:0]    bytes_total;
    } walk_state_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [CLUSTER_W-1:0] first_cluster;
        logic [ADDR_W-1:0]    file_bytes;
        logic [ADDR_W-1:0]    fat_entry_word;
    } walk_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] sector_lba;
        logic [WIDX_W-1:0] fat_word_index;
        logic [CNT_W-1:0]  byte_count;
        logic              last;
    } walk_result_t;

endpackage

/* rtl/core/fcw_step.sv */
// ----------------------------------------------------------------------------
// fcw_step
// next walk state and result for one item against the current state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcw_step
    import fcw_pkg::*;
(
    input  walk_cfg_t    cfg,
    input  walk_state_t  st,
    input  walk_item_t   item,
    output walk_state_t  st_next,
    output logic         emit,
    output walk_result_t res
);

    logic [CLUSTER_W-1:0]       entry;
    logic [CLUSTER_W-1:0]       base_cluster;
    logic [CLUSTER_W-1:0]       base_adj;
    logic [SPC_W+CLUSTER_W-1:0] base_prod;
    logic [ADDR_W-1:0]          base_lba;
    logic [ADDR_W-1:0]          rem;
    logic [ADDR_W-1:0]          cnt_full;

    // one shared base computation, cluster 0 and 1 map to cluster 2
    assign entry        = item.fat_entry_word[CLUSTER_W-1:0];
    assign base_cluster = (item.opcode == OP_START) ? item.first_cluster : entry;
    assign base_adj     = (base_cluster < MIN_CLUSTER) ? MIN_CLUSTER : base_cluster;
    assign base_prod    = (SPC_W+CLUSTER_W)'(cfg.spc)
                        * (SPC_W+CLUSTER_W)'(base_adj - MIN_CLUSTER);
    assign base_lba     = cfg.data_start + base_prod[ADDR_W-1:0];

    assign rem      = st.bytes_total - st.bytes_done;
    assign cnt_full = (rem < ADDR_W'(SECTOR_BYTES)) ? rem : ADDR_W'(SECTOR_BYTES);

    always_comb
    begin
        st_next            = st;
        emit               = 1'b1;
        res.kind           = KIND_ERROR;
        res.sector_lba     = '0;
        res.fat_word_index = '0;
        res.byte_count     = '0;
        res.last           = 1'b0;

        case (item.opcode)
            OP_START:
            begin
                emit                      = 1'b0;
                st_next.phase             = PH_STREAM;
                st_next.chain_cluster     = item.first_cluster;
                st_next.cluster_base      = base_lba;
                st_next.sector_in_cluster = '0;
                st_next.bytes_done        = '0;
                st_next.bytes_total       = item.file_bytes;
            end
            OP_NEXT:
            begin
                if (st.phase == PH_DONE)
                begin
                    res.kind = KIND_EOF;
                end
                else if (st.phase != PH_STREAM)
                begin
                    res.kind = KIND_ERROR;
                end
                else if (st.bytes_done >= st.bytes_total)
                begin
                    res.kind      = KIND_EOF;
                    st_next.phase = PH_DONE;
                end
                else if (st.sector_in_cluster >= cfg.spc)
                begin
                    // cluster used up, fetch its fat entry
                    res.kind           = KIND_FAT;
                    res.sector_lba     = cfg.fat_start
                                       + ADDR_W'(st.chain_cluster >> FAT_SHIFT);
                    res.fat_word_index = WIDX_W'(st.chain_cluster
                                       & CLUSTER_W'(FAT_WORDS - 1));
                    st_next.phase      = PH_WAIT;
                end
                else
                begin
                    res.kind                  = KIND_DATA;
                    res.sector_lba            = st.cluster_base
                                              + ADDR_W'(st.sector_in_cluster);
                    res.byte_count            = CNT_W'(cnt_full);
                    res.last                  = (rem <= ADDR_W'(SECTOR_BYTES));
                    st_next.bytes_done        = st.bytes_done + cnt_full;
                    st_next.sector_in_cluster = st.sector_in_cluster + SPC_W'(1);
                end
            end
            OP_FAT_ENTRY:
            begin
                if (st.phase == PH_WAIT)
                begin
                    if (entry >= CHAIN_END)
                    begin
                        res.kind      = KIND_CHAIN_END;
                        st_next.phase = PH_DONE;
                    end
                    else
                    begin
                        emit                      = 1'b0;
                        st_next.phase             = PH_STREAM;
                        st_next.chain_cluster     = entry;
                        st_next.cluster_base      = base_lba;
                        st_next.sector_in_cluster = '0;
                    end
                end
            end
            default:
            begin
                res.kind = KIND_ERROR;
            end
        endcase
    end

endmodule

/* rtl/core/fat32_cluster_chain_sector_walker.sv */
// an accepted item is held in the input register, its result if any in the
//   result register; one item per cycle while that slot is free or draining,
//   state update (cluster times sectors_per_cluster plus base) in fcw_step
// reset: async active low; walk idle, state zero, config zero with
//   sectors_per_cluster one, both item registers empty
// ----------------------------------------------------------------------------
// fat32_cluster_chain_sector_walker
// follows a file's fat32 cluster chain and issues data and fat sector reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat32_cluster_chain_sector_walker
    import fcw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ADDR_W-1:0]      cfg_wdata,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // first_cluster[27:0], file_bytes[59:28], fat_entry_word[91:60], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]             s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sector_lba[31:0], fat_word_index[38:32], byte_count[48:39], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]             m_axis_tuser,
    // last
    output logic                   m_axis_tlast
);

    localparam int OUT_PAD_W = OUT_TDATA_W - ADDR_W - WIDX_W - CNT_W;

    // configuration registers
    walk_cfg_t    cfg_reg, cfg_next;

    // walk state, updated when an item leaves the input register
    walk_state_t  st_reg;
    walk_state_t  st_next;

    // input register
    logic         in_valid_reg, in_valid_next;
    walk_item_t   in_item_reg;

    // result register
    logic         out_valid_reg, out_valid_next;
    walk_result_t out_res_reg;

    logic         s_accept;
    logic         advance;
    logic         step_emit;
    walk_result_t step_res;

    // an item is processed once the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    fcw_step u_step
    (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .item    (in_item_reg),
        .st_next (st_next),
        .emit    (step_emit),
        .res     (step_res)
    );

    // config writes, indexes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DATA_START: cfg_next.data_start = cfg_wdata;
                CFG_FAT_START:  cfg_next.fat_start  = cfg_wdata;
                CFG_SPC:        cfg_next.spc        = cfg_wdata[SPC_W-1:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = s_accept || (in_valid_reg && !advance);

        if (advance)
        begin
            // items with no result just pass through state
            out_valid_next = step_emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_start       <= '0;
            cfg_reg.fat_start        <= '0;
            cfg_reg.spc              <= SPC_W'(1);
            st_reg.phase             <= PH_IDLE;
            st_reg.chain_cluster     <= '0;
            st_reg.cluster_base      <= '0;
            st_reg.sector_in_cluster <= '0;
            st_reg.bytes_done        <= '0;
            st_reg.bytes_total       <= '0;
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.opcode         <= opcode_t'(s_axis_tuser);
            in_item_reg.first_cluster  <= s_axis_tdata[CLUSTER_W-1:0];
            in_item_reg.file_bytes     <= s_axis_tdata[CLUSTER_W +: ADDR_W];
            in_item_reg.fat_entry_word <= s_axis_tdata[CLUSTER_W+ADDR_W +: ADDR_W];
        end
        if (advance && step_emit)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_res_reg.byte_count,
                            out_res_reg.fat_word_index, out_res_reg.sector_lba};
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.last;

endmodule

/* rtl/core/fcw_checker.sv */
// ----------------------------------------------------------------------------
// fcw_checker
// port-level checks of the walker result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fat32_cluster_chain_sector_walker_macros.svh"

module fcw_checker
    import fcw_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [2:0]             m_axis_tuser,
    input logic                   m_axis_tlast
);

    logic [CNT_W-1:0] out_cnt;
    logic             is_data;

    assign out_cnt = m_axis_tdata[ADDR_W+WIDX_W +: CNT_W];
    assign is_data = (m_axis_tuser == KIND_DATA);

    // stalled result holds
    `FCW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast))

    // only data reads carry a byte count or last
    `FCW_ASSERT_NOW(a_nondata_clean, m_axis_tvalid && !is_data,
        out_cnt == '0 && !m_axis_tlast)

    // a data read always carries between one byte and a full sector
    `FCW_ASSERT_NOW(a_data_count, m_axis_tvalid && is_data,
        out_cnt != '0 && out_cnt <= CNT_W'(SECTOR_BYTES))

    // only fat reads carry a word index
    `FCW_ASSERT_NOW(a_widx_fat_only, m_axis_tvalid && m_axis_tuser != KIND_FAT,
        m_axis_tdata[ADDR_W +: WIDX_W] == '0)

endmodule

bind fat32_cluster_chain_sector_walker fcw_checker u_fcw_checker (.*);

/* tb/fat32_cluster_chain_sector_walker_tb.sv */
// ----------------------------------------------------------------------------
// fat32_cluster_chain_sector_walker_tb
// self-checking bench for the fat32 cluster chain sector walker: commands are
// queued by a planner that tracks the walk, so most of them are well-formed
// file walks that answer fat reads with chain entries. A cycle-level driver and
// monitor check every sector request against an in-bench walk predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat32_cluster_chain_sector_walker_tb
    import fcw_pkg::*;
();

    // opcode the block does not define, must answer a protocol error
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int LBA_LO  = 0;
    localparam int WIDX_LO = ADDR_W;
    localparam int CNT_LO  = ADDR_W + WIDX_W;

    localparam int SETTLE_CYCLES  = 6;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_COMMANDS = 80;
    localparam int SHOWN_ERRORS   = 10;

    // one command item as the bench sees it, opcode kept raw so 3 fits
    typedef struct {
        logic [1:0]           op;
        logic [CLUSTER_W-1:0] first_cluster;
        logic [ADDR_W-1:0]    file_bytes;
        logic [ADDR_W-1:0]    fat_entry_word;
    } walk_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    fat32_cluster_chain_sector_walker uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // register copy shared by predictor and planner, only changed while idle
    walk_cfg_t    disk_cfg;
    // walk state as the block should hold it, advanced at each accepted item
    walk_state_t  walk_now;
    // walk state as the planner expects it once every queued command is taken
    walk_state_t  walk_plan;

    walk_cmd_t    cmd_queue[$];
    walk_cmd_t    bus_cmd;
    walk_result_t due_requests[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycles         = 0;
    int planned        = 0;
    int accepted       = 0;
    int checked        = 0;
    int fail_count     = 0;
    int settings_run   = 0;
    int kind_count[5]  = '{default: 0};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // first sector of a cluster; clusters 0 and 1 land on cluster 2
    function automatic logic [ADDR_W-1:0] cluster_base(input logic [CLUSTER_W-1:0] cl,
                                                       input walk_cfg_t cfg);
        logic [ADDR_W-1:0] eff;
        eff = (cl < MIN_CLUSTER) ? ADDR_W'(MIN_CLUSTER) : ADDR_W'(cl);
        return cfg.data_start + ADDR_W'(cfg.spc) * (eff - ADDR_W'(MIN_CLUSTER));
    endfunction

    // one walk step: updates the state and says which sector request follows
    function automatic void walk_step(inout walk_state_t st, input walk_cfg_t cfg,
                                      input walk_cmd_t cmd, output bit produced,
                                      output walk_result_t res);
        logic [ADDR_W-1:0]    remaining;
        logic [ADDR_W-1:0]    chunk;
        logic [CLUSTER_W-1:0] link;
        res      = '0;
        res.kind = KIND_ERROR;
        produced = 1'b1;
        case (cmd.op)
            OP_START:
            begin
                // restart from any phase, silently
                st.chain_cluster     = cmd.first_cluster;
                st.cluster_base      = cluster_base(cmd.first_cluster, cfg);
                st.sector_in_cluster = '0;
                st.bytes_done        = '0;
                st.bytes_total       = cmd.file_bytes;
                st.phase             = PH_STREAM;
                produced             = 1'b0;
            end
            OP_NEXT:
            begin
                if (st.phase == PH_DONE)
                    res.kind = KIND_EOF;
                else if (st.phase == PH_STREAM)
                begin
                    if (st.bytes_done >= st.bytes_total)
                    begin
                        st.phase = PH_DONE;
                        res.kind = KIND_EOF;
                    end
                    else if (st.sector_in_cluster >= cfg.spc)
                    begin
                        // cluster used up: fetch this cluster's fat entry
                        st.phase           = PH_WAIT;
                        res.kind           = KIND_FAT;
                        res.sector_lba     = cfg.fat_start
                                           + ADDR_W'(st.chain_cluster >> FAT_SHIFT);
                        res.fat_word_index = st.chain_cluster[WIDX_W-1:0];
                    end
                    else
                    begin
                        remaining      = st.bytes_total - st.bytes_done;
                        chunk          = (remaining < ADDR_W'(SECTOR_BYTES))
                                       ? remaining : ADDR_W'(SECTOR_BYTES);
                        res.kind       = KIND_DATA;
                        res.sector_lba = st.cluster_base + ADDR_W'(st.sector_in_cluster);
                        res.byte_count = chunk[CNT_W-1:0];
                        res.last       = (remaining <= ADDR_W'(SECTOR_BYTES));
                        st.bytes_done        = st.bytes_done + chunk;
                        st.sector_in_cluster = st.sector_in_cluster + SPC_W'(1);
                    end
                end
            end
            OP_FAT_ENTRY:
            begin
                if (st.phase == PH_WAIT)
                begin
                    link = cmd.fat_entry_word[CLUSTER_W-1:0];
                    if (link >= CHAIN_END)
                    begin
                        st.phase = PH_DONE;
                        res.kind = KIND_CHAIN_END;
                    end
                    else
                    begin
                        st.chain_cluster     = link;
                        st.cluster_base      = cluster_base(link, cfg);
                        st.sector_in_cluster = '0;
                        st.phase             = PH_STREAM;
                        produced             = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // command driver: takes the next queued item when the bus is free, or
    // idles at random; prediction happens at the edge the item is accepted
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive
        bit           produced;
        walk_result_t res;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                walk_step(walk_now, disk_cfg, bus_cmd, produced, res);
                if (produced)
                    due_requests.push_back(res);
                accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    bus_cmd = cmd_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= bus_cmd.op;
                    s_axis_tdata  <= {{(IN_TDATA_W - CLUSTER_W - 2 * ADDR_W){1'b0}},
                                      bus_cmd.fat_entry_word, bus_cmd.file_bytes,
                                      bus_cmd.first_cluster};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request monitor: random back-pressure, every accepted item is matched
    // against the oldest predicted sector request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        walk_result_t want;
        logic         bad;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_requests.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS)
                        $display("[%0t] unexpected item: kind %0d lba %h", $realtime,
                                 m_axis_tuser, m_axis_tdata[LBA_LO +: ADDR_W]);
                end
                else
                begin
                    want = due_requests.pop_front();
                    checked++;
                    kind_count[int'(want.kind)]++;
                    bad = (m_axis_tuser !== want.kind)
                       || (m_axis_tdata[LBA_LO +: ADDR_W] !== want.sector_lba)
                       || (m_axis_tdata[WIDX_LO +: WIDX_W] !== want.fat_word_index)
                       || (m_axis_tdata[CNT_LO +: CNT_W] !== want.byte_count)
                       || (m_axis_tlast !== want.last);
                    if (bad)
                    begin
                        fail_count++;
                        if (fail_count <= SHOWN_ERRORS)
                            $display({"[%0t] mismatch: kind %0d/%0d lba %h/%h ",
                                      "widx %0d/%0d count %0d/%0d last %0b/%0b (exp/got)"},
                                     $realtime, want.kind, m_axis_tuser,
                                     want.sector_lba, m_axis_tdata[LBA_LO +: ADDR_W],
                                     want.fat_word_index, m_axis_tdata[WIDX_LO +: WIDX_W],
                                     want.byte_count, m_axis_tdata[CNT_LO +: CNT_W],
                                     want.last, m_axis_tlast);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // register write, only called while nothing is in flight
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_DATA_START: disk_cfg.data_start = val;
            CFG_FAT_START:  disk_cfg.fat_start  = val;
            CFG_SPC:        disk_cfg.spc        = val[SPC_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // queue a command and advance the planner's view of the walk
    task automatic push_cmd(input logic [1:0] op, input logic [CLUSTER_W-1:0] cl,
                            input logic [ADDR_W-1:0] len, input logic [ADDR_W-1:0] entry);
        walk_cmd_t    cmd;
        bit           produced;
        walk_result_t res;
        cmd.op             = op;
        cmd.first_cluster  = cl;
        cmd.file_bytes     = len;
        cmd.fat_entry_word = entry;
        walk_step(walk_plan, disk_cfg, cmd, produced, res);
        cmd_queue.push_back(cmd);
        planned++;
    endtask

    // unused fields carry random bits so every field bit toggles
    task automatic push_next();
        push_cmd(OP_NEXT, CLUSTER_W'($urandom), $urandom, $urandom);
    endtask

    task automatic push_entry(input logic [ADDR_W-1:0] entry);
        push_cmd(OP_FAT_ENTRY, CLUSTER_W'($urandom), $urandom, entry);
    endtask

    // chain entry: mostly a next cluster, sometimes the end mark, a low one or random bits
    function automatic logic [ADDR_W-1:0] chain_entry();
        logic [3:0] junk;
        junk = 4'($urandom);
        case ($urandom_range(0, 7))
            0: return {junk, CHAIN_END + 28'($urandom_range(0, 7))};
            1: return {junk, 28'($urandom_range(0, 1))};
            2: return $urandom;
            default: return {junk, 28'($urandom_range(2, 100000))};
        endcase
    endfunction

    // one file walk: start, then requests, answering every fat read
    task automatic plan_walk();
        logic [CLUSTER_W-1:0] cl;
        logic [ADDR_W-1:0]    len;
        int                   budget;
        case ($urandom_range(0, 5))
            0: cl = CLUSTER_W'($urandom_range(0, 1));
            1: cl = CLUSTER_W'($urandom);
            2: cl = 28'hFFF_FFFF - 28'($urandom_range(0, 3));
            default: cl = CLUSTER_W'($urandom_range(2, 5000));
        endcase
        case ($urandom_range(0, 9))
            0: len = '0;
            1: len = SECTOR_BYTES * $urandom_range(1, 8);
            2: len = $urandom;
            3: len = 32'hFFFF_FFFF - $urandom_range(0, 600);
            default: len = $urandom_range(1, 4000);
        endcase
        push_cmd(OP_START, cl, len, $urandom);
        budget = $urandom_range(4, 30);
        while (budget > 0)
        begin
            budget--;
            if ($urandom_range(0, 19) == 0)
                // noise: anything at all, including the undefined opcode
                push_cmd(2'($urandom_range(0, 3)), CLUSTER_W'($urandom), $urandom, $urandom);
            else if (walk_plan.phase == PH_WAIT)
                push_entry(chain_entry());
            else
            begin
                push_next();
                if (walk_plan.phase == PH_DONE && $urandom_range(0, 1) == 0)
                    budget = 0;
            end
        end
    endtask

    // sender pause until every predicted request has come back
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || s_axis_tvalid || due_requests.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus: directed corner cases, then random walks under several
    // register settings and idle patterns
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int quota;
        disk_cfg      = '{data_start: '0, fat_start: '0, spc: 8'd1};
        walk_now      = '{phase: PH_IDLE, default: '0};
        walk_plan     = walk_now;
        wait (rst_n === 1'b1);
        @(negedge clk);

        // addresses close to the top so data and fat lbas wrap
        set_reg(CFG_DATA_START, 32'hFFFF_FFF0);
        set_reg(CFG_FAT_START, 32'hFFFF_FFFF);
        set_reg(CFG_SPC, 32'd2);
        settings_run++;

        // wrong phase while idle, and the undefined opcode
        push_next();
        push_entry(32'h0000_0005);
        push_cmd(OP_UNUSED, '0, '0, '0);
        // empty file, then requests in the finished phase
        push_cmd(OP_START, 28'd0, 32'd0, '0);
        push_next();
        push_next();
        push_entry(32'h0000_0007);
        // low first cluster, partial tail, request while waiting, masked entry
        push_cmd(OP_START, 28'd1, 32'd1300, '0);
        push_next();
        push_next();
        push_next();
        push_next();
        push_entry(32'hF000_0005);
        push_next();
        push_next();
        // highest cluster and size: fat word 127, lba wrap, end of chain
        push_cmd(OP_START, 28'hFFF_FFFF, 32'hFFFF_FFFF, '0);
        push_next();
        push_next();
        push_next();
        push_entry(32'h0FFF_FFF8);
        push_next();
        // one exact sector, then a restart in the middle of a walk
        push_cmd(OP_START, 28'd2, 32'd512, '0);
        push_next();
        push_cmd(OP_START, 28'd3, 32'd513, '0);
        push_next();
        push_next();
        push_next();
        push_entry(32'hFFFF_FFFF);
        wait_quiet();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    src_idle_pct = 0;  sink_stall_pct = 0;
                    set_reg(CFG_DATA_START, 32'h0000_0800);
                    set_reg(CFG_FAT_START, 32'h0000_0020);
                    set_reg(CFG_SPC, 32'd1);
                end
                1:
                begin
                    src_idle_pct = 72; sink_stall_pct = 0;
                    set_reg(CFG_DATA_START, $urandom);
                    set_reg(CFG_FAT_START, $urandom);
                    set_reg(CFG_SPC, 32'd4);
                end
                2:
                begin
                    // zero sectors per cluster: every streaming request short of end of file wants a fat read
                    src_idle_pct = 0;  sink_stall_pct = 72;
                    set_reg(CFG_DATA_START, 32'hFFFF_FFFF);
                    set_reg(CFG_FAT_START, 32'hFFFF_FF80);
                    set_reg(CFG_SPC, 32'd0);
                end
                3:
                begin
                    src_idle_pct = 30; sink_stall_pct = 30;
                    set_reg(CFG_DATA_START, 32'd0);
                    set_reg(CFG_FAT_START, 32'd0);
                    set_reg(CFG_SPC, 32'd128);
                end
                4:
                begin
                    // upper bits of the register write are dropped
                    src_idle_pct = 0;  sink_stall_pct = 0;
                    set_reg(CFG_DATA_START, $urandom);
                    set_reg(CFG_FAT_START, $urandom);
                    set_reg(CFG_SPC, 32'hFFFF_FFFF);
                end
                default:
                begin
                    src_idle_pct = 30; sink_stall_pct = 30;
                    set_reg(CFG_DATA_START, 32'h0000_1000);
                    set_reg(CFG_FAT_START, 32'h0000_0040);
                    set_reg(CFG_SPC, $urandom_range(1, 8));
                end
            endcase
            settings_run++;
            quota = planned + PHASE_COMMANDS;
            while (planned < quota)
                plan_walk();
            wait_quiet();
        end

        if (due_requests.size() != 0)
            fail_count++;
        $display("walker run: %0d commands, %0d sector requests checked, %0d register settings",
                 accepted, checked, settings_run);
        $display("requests by kind: data %0d, fat %0d, eof %0d, chain end %0d, error %0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/fcw_pkg.sv
rtl/core/fcw_step.sv
rtl/core/fat32_cluster_chain_sector_walker.sv
rtl/core/fcw_checker.sv
tb/fat32_cluster_chain_sector_walker_tb.sv
